>>> design/sdtl_pkg.sv
`default_nettype none
package sdtl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // root search: 9 cells, one per bit of the odd-multiple index
  localparam int NCELL = 9;
  localparam int RW = 56;

  localparam logic [7:0] REG_MATCH_RADIUS = 8'd0;
  localparam logic [7:0] REG_THIN_WIDTH   = 8'd1;
  localparam logic [7:0] REG_THICK_WIDTH  = 8'd2;
  localparam logic [7:0] REG_VERTEX_COLOR = 8'd3;

  typedef struct packed {
    logic [15:0] mag;
    logic [9:0]  w;
    logic [32:0] s;
  } job_t;

  typedef struct packed {
    logic          v;
    logic          ok;
    logic [51:0]   nn;
    logic [RW-1:0] s;
    logic [RW-1:0] a;
    logic [RW-1:0] b;
    logic [8:0]    j;
  } cell_t;

  typedef struct packed {
    logic       v;
    logic [9:0] k;
  } res_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) r = 16'h7fff;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/sdtl_if.sv
`default_nettype none
interface sdtl_seg_if;
  logic valid;
  logic ready;
  logic signed [15:0] tail_x;
  logic signed [15:0] tail_y;
  logic signed [15:0] head_x;
  logic signed [15:0] head_y;
  modport source(output valid, tail_x, tail_y, head_x, head_y, input ready);
  modport sink(input valid, tail_x, tail_y, head_x, head_y, output ready);
endinterface

interface sdtl_vtx_if;
  logic valid;
  logic ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic [23:0] color;
  logic table_full;
  logic last;
  modport source(output valid, vertex_x, vertex_y, color, table_full, last, input ready);
  modport sink(input valid, vertex_x, vertex_y, color, table_full, last, output ready);
endinterface

interface sdtl_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/sdtl_cell.sv
`default_nettype none
module sdtl_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       pos,
  input  sdtl_pkg::cell_t  d,
  output sdtl_pkg::cell_t  q
);
  import sdtl_pkg::*;

  logic [5:0] sh0, sh1, sh2;
  logic [RW-1:0] cand;
  logic take;
  cell_t nxt, r;

  // try bit pos: (a + 2^(pos+1))^2 * s from a^2*s and a*s
  always_comb begin
    sh0 = {2'b0, pos} + 6'd1;
    sh1 = {2'b0, pos} + 6'd2;
    sh2 = {1'b0, pos, 1'b0} + 6'd2;
    cand = d.a + (d.b << sh1) + (d.s << sh2);
    take = d.ok && (cand <= RW'(d.nn));
    nxt = d;
    if (take) begin
      nxt.a = cand;
      nxt.b = d.b + (d.s << sh0);
      nxt.j = d.j | (9'd1 << pos);
    end
    if (rst) nxt.v = 1'b0;
  end

  always_ff @(posedge clk) begin
    r <= nxt;
  end

  assign q = r;
endmodule
`default_nettype wire

>>> design/sdtl_root_chain.sv
`default_nettype none
module sdtl_root_chain (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_v,
  input  sdtl_pkg::job_t  job,
  output sdtl_pkg::res_t  res
);
  import sdtl_pkg::*;

  logic        av, bv;
  logic [25:0] num;
  logic [32:0] sa, sb;
  logic [51:0] nn;
  cell_t       c [NCELL+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
      bv <= 1'b0;
    end else begin
      av <= job_v;
      bv <= av;
    end
    num <= job.mag * job.w;
    sa  <= job.s;
    nn  <= num * num;
    sb  <= sa;
  end

  always_comb begin
    c[0].v  = bv;
    c[0].ok = (sb != 33'd0) && (RW'(sb) <= RW'(nn));
    c[0].nn = nn;
    c[0].s  = RW'(sb);
    c[0].a  = RW'(sb);
    c[0].b  = RW'(sb);
    c[0].j  = 9'd0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    sdtl_cell u_cell (
      .clk (clk),
      .rst (rst),
      .pos (4'(NCELL - 1 - i)),
      .d   (c[i]),
      .q   (c[i+1])
    );
  end

  assign res.v = c[NCELL].v;
  assign res.k = c[NCELL].ok ? (10'(c[NCELL].j) + 10'd1) : 10'd0;
endmodule
`default_nettype wire

>>> design/segment_dedup_thick_line.sv
`default_nettype none
// An accepted segment is scanned against the N stored segments, one entry per cycle,
// then passes the 11-stage root chain before its first vertex; a match goes idle with
// no output. A new segment is accepted only in idle, so the segment rate is set by the
// scan, the root chain and how fast the vertices are taken.
// Reset: synchronous, clears the stored count and loads default registers;
// table contents are not cleared and are only read below the count.
module segment_dedup_thick_line (
  input logic clk,
  input logic rst,
  sdtl_seg_if.sink   seg,
  sdtl_vtx_if.source vtx,
  sdtl_cfg_if.sink   cfg
);
  import sdtl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_PREP = 6'b000100,
    S_SQR  = 6'b001000,
    S_CALC = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state;
  logic [9:0]  radius, thin_w, thick_w;
  logic [23:0] color_r;
  logic signed [15:0] tx, ty, hx, hy;
  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd;
  logic [CNT_W-1:0] cnt, ptr;
  logic p1v, p2v;
  logic [33:0] sq0, sq1, sq2, sq3;
  logic signed [16:0] d0, d1, d2, d3, dx, dy;
  logic [19:0] r2;
  logic match, wr_en;
  logic [15:0] adx, ady;
  logic dx_pos, dy_neg, full;
  logic [31:0] sx2, sy2;
  logic [2:0] jobn, got, vi;
  logic job_v;
  job_t job;
  res_t res;
  logic [9:0] k0, k1, k2, k3, kx, ky;
  logic signed [11:0] ox, oy;
  logic signed [17:0] bx, by, vx, vy;
  logic load, ov;
  logic [15:0] out_x, out_y;
  logic [23:0] out_c;
  logic out_full, out_last;

  assign seg.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    d0 = 17'(signed'(rd[15:0]))  - 17'(tx);
    d1 = 17'(signed'(rd[31:16])) - 17'(ty);
    d2 = 17'(signed'(rd[47:32])) - 17'(hx);
    d3 = 17'(signed'(rd[63:48])) - 17'(hy);
    r2 = radius * radius;
    match = p2v && ((35'(sq2) + 35'(sq3)) <= 35'(r2)) && ((35'(sq0) + 35'(sq1)) <= 35'(r2));
    dx = 17'(hx) - 17'(tx);
    dy = 17'(hy) - 17'(ty);
    wr_en = (state == S_PREP) && (cnt != CNT_W'(TABLE_DEPTH));
    job_v = (state == S_CALC) && !jobn[2];
    job.mag = jobn[0] ? adx : ady;
    job.w   = jobn[1] ? thick_w : thin_w;
    job.s   = 33'(sx2) + 33'(sy2);
    kx = vi[2] ? k2 : k0;
    ky = vi[2] ? k3 : k1;
    ox = dy_neg ? -$signed({2'b0, kx}) : $signed({2'b0, kx});
    oy = dx_pos ? -$signed({2'b0, ky}) : $signed({2'b0, ky});
    bx = (vi[1] == vi[0]) ? 18'(tx) : 18'(hx);
    by = (vi[1] == vi[0]) ? 18'(ty) : 18'(hy);
    vx = vi[1] ? (bx - 18'(ox)) : (bx + 18'(ox));
    vy = vi[1] ? (by - 18'(oy)) : (by + 18'(oy));
    load = (state == S_EMIT) && (!ov || vtx.ready);
  end

  sdtl_root_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .job_v (job_v),
    .job   (job),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt[TBL_AW-1:0]] <= {hy, hx, ty, tx};
    rd <= mem[ptr[TBL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    sq0 <= 34'(d0 * d0);
    sq1 <= 34'(d1 * d1);
    sq2 <= 34'(d2 * d2);
    sq3 <= 34'(d3 * d3);
    if (seg.valid && seg.ready) begin
      tx <= seg.tail_x;
      ty <= seg.tail_y;
      hx <= seg.head_x;
      hy <= seg.head_y;
    end
    if (state == S_PREP) begin
      adx <= 16'((dx < 0) ? -dx : dx);
      ady <= 16'((dy < 0) ? -dy : dy);
      dx_pos <= (dx > 0);
      dy_neg <= (dy < 0);
      full <= !wr_en;
    end
    if (state == S_SQR) begin
      sx2 <= adx * adx;
      sy2 <= ady * ady;
    end
    if (state == S_CALC && res.v) begin
      case (got[1:0])
        2'd0: k0 <= res.k;
        2'd1: k1 <= res.k;
        2'd2: k2 <= res.k;
        default: k3 <= res.k;
      endcase
    end
    if (load) begin
      out_x <= sat16(vx);
      out_y <= sat16(vy);
      out_c <= color_r;
      out_full <= full;
      out_last <= (vi == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radius <= 10'd48;
      thin_w <= 10'd16;
      thick_w <= 10'd48;
      color_r <= 24'd64000;
      cnt <= '0;
      ptr <= '0;
      p1v <= 1'b0;
      p2v <= 1'b0;
      jobn <= '0;
      got <= '0;
      vi <= '0;
      ov <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_MATCH_RADIUS: radius <= cfg.data[9:0];
          REG_THIN_WIDTH:   thin_w <= cfg.data[9:0];
          REG_THICK_WIDTH:  thick_w <= cfg.data[9:0];
          REG_VERTEX_COLOR: color_r <= cfg.data;
          default: ;
        endcase
      end
      if (load) ov <= 1'b1;
      else if (vtx.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            ptr <= '0;
            p1v <= 1'b0;
            p2v <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            p1v <= 1'b0;
            p2v <= 1'b0;
            state <= S_IDLE;
          end else begin
            if (ptr != cnt) begin
              p1v <= 1'b1;
              ptr <= ptr + CNT_W'(1);
            end else begin
              p1v <= 1'b0;
            end
            p2v <= p1v;
            if (ptr == cnt && !p1v && !p2v) state <= S_PREP;
          end
        end
        S_PREP: begin
          if (wr_en) cnt <= cnt + CNT_W'(1);
          state <= S_SQR;
        end
        S_SQR: begin
          jobn <= '0;
          got <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          if (job_v) jobn <= jobn + 3'd1;
          if (res.v) begin
            got <= got + 3'd1;
            if (got == 3'd3) begin
              vi <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            vi <= vi + 3'd1;
            if (vi == 3'd7) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign vtx.valid = ov;
  assign vtx.vertex_x = out_x;
  assign vtx.vertex_y = out_y;
  assign vtx.color = out_c;
  assign vtx.table_full = out_full;
  assign vtx.last = out_last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH)) else $error("stored count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |-> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("stored count moved by more than one");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (seg.valid && seg.ready) |=> (state == S_SCAN))
    else $error("accepted segment did not start a scan");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (ptr <= cnt)) else $error("scan pointer past stored count");
`endif

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import sdtl_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd9;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
  } seg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] color;
    logic        full;
    logic        last;
  } vertex_t;

  // directed row: zero_len and dup have their results typed in
  typedef struct {
    seg_t s;
    bit   zero_len;
    bit   dup;
  } row_t;

  logic clk;
  logic rst;

  sdtl_seg_if seg();
  sdtl_vtx_if vtx();
  sdtl_cfg_if cfg();

  segment_dedup_thick_line dut (
    .clk(clk),
    .rst(rst),
    .seg(seg),
    .vtx(vtx),
    .cfg(cfg)
  );

  logic [9:0]  radius_q;
  logic [9:0]  thin_q;
  logic [9:0]  thick_q;
  logic [23:0] color_q;
  seg_t        stored[TABLE_DEPTH];
  int          stored_cnt;
  seg_t        sent_hist[$];
  vertex_t     vertex_queue[$];
  int          errors;
  bit          hold_req;
  bit          rx_always;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned sq_dist(int ax, int ay, int bx, int by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic int round_offset(int c, int w, longint unsigned s);
    longint unsigned num;
    longint unsigned nn;
    longint unsigned k;
    if (s == 0) return 0;
    num = longint'(c < 0 ? -c : c) * w;
    nn = num * num;
    k = 0;
    while (k < 512 && nn >= (2 * k + 1) * (2 * k + 1) * s) k++;
    return c < 0 ? -int'(k) : int'(k);
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void push_vertex(int x, int y, bit full, int n);
    vertex_t v;
    v.x = clamp16(x);
    v.y = clamp16(y);
    v.color = color_q;
    v.full = full;
    v.last = (n == 7);
    vertex_queue = {vertex_queue, v};
  endfunction

  // dedup against the table, store, then emit thin and thick quads when emit is set
  function automatic void predict_segment(seg_t s, bit emit);
    int tx;
    int ty;
    int hx;
    int hy;
    int dx;
    int dy;
    int ox;
    int oy;
    int w;
    bit full;
    longint unsigned r2;
    longint unsigned len2;
    tx = s.tx;
    ty = s.ty;
    hx = s.hx;
    hy = s.hy;
    r2 = longint'(radius_q) * radius_q;
    for (int i = 0; i < stored_cnt; i++) begin
      if (sq_dist(stored[i].hx, stored[i].hy, hx, hy) <= r2 &&
          sq_dist(stored[i].tx, stored[i].ty, tx, ty) <= r2) return;
    end
    full = 1'b0;
    if (stored_cnt < TABLE_DEPTH) begin
      stored[stored_cnt] = s;
      stored_cnt++;
    end else begin
      full = 1'b1;
    end
    if (!emit) return;
    dx = hx - tx;
    dy = hy - ty;
    len2 = sq_dist(hx, hy, tx, ty);
    for (int q = 0; q < 2; q++) begin
      w = (q == 0) ? thin_q : thick_q;
      ox = round_offset(dy, w, len2);
      oy = round_offset(-dx, w, len2);
      push_vertex(tx + ox, ty + oy, full, 4 * q);
      push_vertex(hx + ox, hy + oy, full, 4 * q + 1);
      push_vertex(hx - ox, hy - oy, full, 4 * q + 2);
      push_vertex(tx - ox, ty - oy, full, 4 * q + 3);
    end
  endfunction

  task automatic send_seg(seg_t s);
    int gap;
    int pick;
    pick = $urandom_range(0, 19);
    gap = (pick < 10) ? 0 : (pick < 18) ? $urandom_range(1, 3) : $urandom_range(20, 80);
    if (gap > 0) begin
      seg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg.valid <= 1'b1;
    seg.tail_x <= s.tx;
    seg.tail_y <= s.ty;
    seg.head_x <= s.hx;
    seg.head_y <= s.hy;
    do @(posedge clk); while (!seg.ready);
    sent_hist = {sent_hist, s};
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_MATCH_RADIUS: radius_q = data[9:0];
      REG_THIN_WIDTH:   thin_q = data[9:0];
      REG_THICK_WIDTH:  thick_q = data[9:0];
      REG_VERTEX_COLOR: color_q = data;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    seg.valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(int r, int tw, int kw, int c);
    write_reg(REG_MATCH_RADIUS, 24'(r));
    write_reg(REG_THIN_WIDTH, 24'(tw));
    write_reg(REG_THICK_WIDTH, 24'(kw));
    write_reg(REG_VERTEX_COLOR, 24'(c));
  endtask

  function automatic seg_t random_seg();
    seg_t s;
    int pick;
    int j;
    pick = $urandom_range(0, 99);
    s.tx = 16'($urandom);
    s.ty = 16'($urandom);
    if (pick < 45 || sent_hist.size() == 0) begin
      s.hx = 16'($urandom);
      s.hy = 16'($urandom);
    end else if (pick < 70) begin
      s.hx = s.tx + $signed(16'($urandom_range(0, 400)) - 16'd200);
      s.hy = s.ty + $signed(16'($urandom_range(0, 400)) - 16'd200);
    end else if (pick < 92) begin
      // exact or near repeat of an earlier segment
      s = sent_hist[$urandom_range(0, sent_hist.size() - 1)];
      j = $urandom_range(0, 3);
      if (j > 0) begin
        s.tx += $signed(16'($urandom_range(0, 60)) - 16'd30);
        s.hy += $signed(16'($urandom_range(0, 60)) - 16'd30);
      end
    end else if (pick < 96) begin
      s.hx = s.tx;
      s.hy = s.ty;
    end else begin
      s.tx = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      s.hx = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      s.hy = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end
    return s;
  endfunction

  task automatic run_random(int count, int hold_at, int pause_at);
    seg_t s;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) begin
        seg.valid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge clk);
      end
      s = random_seg();
      send_seg(s);
      predict_segment(s, 1'b1);
    end
  endtask

  // receiver: random stalls or always ready with rx_always, one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    vertex_t e;
    stall_left = 0;
    hold_left = 0;
    vtx.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (vtx.valid && vtx.ready) begin
        if (vertex_queue.size() == 0) begin
          report("unexpected vertex x", vtx.vertex_x, 0);
        end else begin
          e = vertex_queue.pop_front();
          if (vtx.vertex_x !== e.x) report("vertex_x", vtx.vertex_x, $signed(e.x));
          if (vtx.vertex_y !== e.y) report("vertex_y", vtx.vertex_y, $signed(e.y));
          if (vtx.color !== e.color) report("color", vtx.color, e.color);
          if (vtx.table_full !== e.full) report("table_full", vtx.table_full, e.full);
          if (vtx.last !== e.last) report("last", vtx.last, e.last);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        vtx.ready <= 1'b0;
      end else if (rx_always) begin
        vtx.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        vtx.ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
        vtx.ready <= 1'b0;
      end else begin
        vtx.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((seg.valid && seg.ready) || (vtx.valid && vtx.ready) || (cfg.valid && cfg.ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("FAIL segment_dedup_thick_line");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    errors = 0;
    hold_req = 1'b0;
    rx_always = 1'b0;
    stored_cnt = 0;
    radius_q = 10'd48;
    thin_q = 10'd16;
    thick_q = 10'd48;
    color_q = 24'd64000;
    rst <= 1'b1;
    seg.valid <= 1'b0;
    seg.tail_x <= '0;
    seg.tail_y <= '0;
    seg.head_x <= '0;
    seg.head_y <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, 0},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0, 1},
      '{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1, 0},
      '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 0, 0},
      '{'{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000}, 0, 0},
      '{'{16'sd100, 16'sd200, 16'sd1000, 16'sd200}, 0, 0},
      '{'{16'sd100, 16'sd200, 16'sd100, -16'sd900}, 0, 0},
      '{'{16'sd148, 16'sd200, 16'sd1000, 16'sd200}, 0, 1},
      '{'{16'sd149, 16'sd200, 16'sd1000, 16'sd200}, 0, 0},
      '{'{16'sd130, 16'sd240, 16'sd970, 16'sd160}, 0, 0},
      '{'{-16'sd500, -16'sd600, -16'sd510, -16'sd590}, 0, 0},
      '{'{16'sd1, 16'sd1, 16'sd2, 16'sd1}, 0, 0},
      '{'{16'sd0, 16'sd0, 16'sd1, 16'sd1}, 0, 0},
      '{'{16'sh8000, 16'sd0, 16'sh8000, 16'sd0}, 1, 0},
      '{'{16'sd20000, -16'sd20000, -16'sd20000, 16'sd20000}, 0, 0},
      '{'{16'sd5, -16'sd5, -16'sd5, 16'sd5}, 0, 0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_seg(r.s);
      if (r.zero_len) begin
        for (int n = 0; n < 8; n++) push_vertex(r.s.tx, r.s.ty, 1'b0, n);
        predict_segment(r.s, 1'b0);
      end else if (r.dup) begin
        predict_segment(r.s, 1'b0);
      end else begin
        predict_segment(r.s, 1'b1);
      end
    end
    wait_drain();

    rx_always = 1'b1;
    set_regs(0, 0, 1023, 24'hffffff);
    write_reg(REG_UNUSED, 24'h000123);
    run_random(100, -1, -1);
    wait_drain();

    rx_always = 1'b0;
    set_regs(1023, 1023, 0, 0);
    run_random(100, 30, -1);
    wait_drain();

    set_regs($urandom_range(1, 1022), $urandom_range(1, 1022), $urandom_range(1, 1022),
             $urandom_range(1, 24'hfffffe));
    run_random(200, -1, 90);
    wait_drain();

    if (errors == 0) begin
      $display("PASS segment_dedup_thick_line");
    end else begin
      $display("FAIL segment_dedup_thick_line");
    end
    $finish;
  end

endmodule
